// ----- src/vur_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the video unit register interface.
// No dependencies.
package vur_pkg;

  // Item function codes
  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_READ  = 2'd1,
    FUNC_WRITE = 2'd2
  } vur_func_t;

  // Register numbers
  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OBJ_ADDR = 3'd3;
  localparam logic [2:0] REG_OBJ_DATA = 3'd4;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  // Defaults for top-level parameters
  localparam int VUR_VRAM_BYTES      = 2048;
  localparam int VUR_DOTS_PER_LINE   = 341;
  localparam int VUR_LINES_PER_FRAME = 262;

  // Fixed geometry
  localparam int PAL_BYTES = 32;
  localparam int PAL_AW    = 5;
  localparam int CNT_W     = 9;

  localparam logic [CNT_W-1:0] VBLANK_SET_LINE = 9'd241;
  localparam logic [CNT_W-1:0] VBLANK_CLR_LINE = 9'd261;

  localparam logic [15:0] NT_BASE  = 16'h2000;
  localparam logic [15:0] NT_LAST  = 16'h3EFF;
  localparam logic [15:0] PAL_BASE = 16'h3F00;

  localparam int CTRL_NMI_BIT = 7;
  localparam int CTRL_INC_BIT = 2;

  // Video RAM port command
  typedef struct packed {
    logic wr;
    logic rd;
  } vur_ram_cmd_t;

endpackage

// ----- src/vur_vram.sv -----
`timescale 1ns / 1ps
// Video RAM: single write port, single registered read port, zero sweep after reset.
// Depends on vur_pkg.
module vur_vram
  import vur_pkg::*;
#(
  parameter int VRAM_BYTES = VUR_VRAM_BYTES,
  parameter int AW         = $clog2(VRAM_BYTES)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  vur_ram_cmd_t  cmd,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata,
  output logic          busy
);

  localparam logic [AW-1:0] LAST_IDX = AW'(VRAM_BYTES - 1);

  logic [7:0]    mem [VRAM_BYTES];
  logic [7:0]    rdata_r;
  logic          busy_r;
  logic          busy_nxt;
  logic [AW-1:0] clr_idx_r;
  logic [AW-1:0] clr_idx_nxt;

  // clear sweep, one entry per cycle
  always_comb begin
    busy_nxt    = busy_r;
    clr_idx_nxt = clr_idx_r;
    if (busy_r) begin
      clr_idx_nxt = clr_idx_r + AW'(1);
      if (clr_idx_r == LAST_IDX) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b1;
      clr_idx_r <= '0;
    end else begin
      busy_r    <= busy_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r) begin
      mem[clr_idx_r] <= 8'h00;
    end else if (cmd.wr) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = busy_r;

endmodule

// ----- src/video_unit_register_interface.sv -----
`timescale 1ns / 1ps
// Top level of the video unit register interface: registers, dot/line timing, output stage.
// Depends on vur_pkg and vur_vram.
//
// Usage
//   Input channel (in_valid/in_ready): one item per access, in_func selects a dot tick,
//   a register read or a register write; in_reg_select and in_write_data qualify it.
//   Result channel (out_valid/out_ready): exactly one result item per input item, in order:
//   read byte (0 for ticks and writes), NMI pulse and end-of-frame flag.
//   Latency: the result of an item is presented the cycle after it is accepted.
//   Throughput: one item per clock. Each item is handled in the cycle it is accepted;
//   the single-port video RAM is read or written at most once per item, and a data-port
//   read returns the previously fetched byte while the new fetch lands in the RAM's
//   read register, which then serves as the read buffer.
//   Stalls: the result register holds while out_ready is low; in_ready follows it, so a
//   new item enters only when the held result leaves in the same cycle.
//   Reset (rst_n, synchronous, active low) clears the architectural registers and out_valid and
//   starts a sweep that zeroes the video RAM (2048 bytes by default), one byte per cycle, with
//   in_ready low throughout. The palette is write-only and holds nothing the outputs can observe.
module video_unit_register_interface
  import vur_pkg::*;
#(
  parameter int VRAM_BYTES      = VUR_VRAM_BYTES,
  parameter int DOTS_PER_LINE   = VUR_DOTS_PER_LINE,
  parameter int LINES_PER_FRAME = VUR_LINES_PER_FRAME
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_func,
  input  logic [2:0] in_reg_select,
  input  logic [7:0] in_write_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_read_data,
  output logic       out_nmi_pulse,
  output logic       out_frame_done
);

  localparam int AW = $clog2(VRAM_BYTES);
  localparam logic [CNT_W:0] DOTS_LIM  = (CNT_W+1)'(DOTS_PER_LINE);
  localparam logic [CNT_W:0] LINES_LIM = (CNT_W+1)'(LINES_PER_FRAME);
  // multiples of the RAM size for the offset reduction (offset < 8 * VRAM_BYTES)
  localparam logic [15:0] RAM_X4 = 16'(4 * VRAM_BYTES);
  localparam logic [15:0] RAM_X2 = 16'(2 * VRAM_BYTES);
  localparam logic [15:0] RAM_X1 = 16'(VRAM_BYTES);

  // architectural registers
  logic [7:0]       ctrl_r,     ctrl_nxt;
  logic [7:0]       mask_r,     mask_nxt;
  logic [7:0]       obj_addr_r, obj_addr_nxt;
  logic [7:0]       obj_data_r, obj_data_nxt;
  logic             vblank_r,   vblank_nxt;
  logic [15:0]      vaddr_r,    vaddr_nxt;
  logic [15:0]      taddr_r,    taddr_nxt;
  logic             toggle_r,   toggle_nxt;
  logic             buf_vld_r,  buf_vld_nxt;
  logic [CNT_W-1:0] dot_r,      dot_nxt;
  logic [CNT_W-1:0] line_r,     line_nxt;

  // result stage
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] rd_data_r,   rd_data_nxt;
  logic       nmi_r,       nmi_nxt;
  logic       frame_r,     frame_nxt;

  logic [7:0]   pal_mem [PAL_BYTES];
  logic         pal_we;

  vur_ram_cmd_t ram_cmd;
  logic [AW-1:0] ram_addr;
  logic [7:0]   ram_rdata;
  logic         ram_busy;

  logic         accept;
  logic [7:0]   buf_val;
  logic [15:0]  nt_off;
  logic [15:0]  red4;
  logic [15:0]  red2;
  logic [15:0]  red1;
  logic         in_nt;
  logic [15:0]  vaddr_inc;
  logic [CNT_W:0] dot_sum;
  logic [CNT_W:0] line_sum;

  assign in_ready = !ram_busy && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  // read buffer lives in the RAM read register once the first fetch has happened
  assign buf_val = buf_vld_r ? ram_rdata : 8'h00;

  // map vaddr to a RAM index: name-table window, modulo RAM size, else index 0
  always_comb begin
    in_nt  = (vaddr_r >= NT_BASE) && (vaddr_r <= NT_LAST);
    nt_off = vaddr_r - NT_BASE;
    red4   = (nt_off >= RAM_X4) ? nt_off - RAM_X4 : nt_off;
    red2   = (red4 >= RAM_X2) ? red4 - RAM_X2 : red4;
    red1   = (red2 >= RAM_X1) ? red2 - RAM_X1 : red2;
    ram_addr = in_nt ? red1[AW-1:0] : '0;
  end

  assign vaddr_inc = ctrl_r[CTRL_INC_BIT] ? 16'd32 : 16'd1;
  assign dot_sum   = {1'b0, dot_r} + (CNT_W+1)'(1);
  assign line_sum  = {1'b0, line_r} + (CNT_W+1)'(1);

  always_comb begin
    ctrl_nxt      = ctrl_r;
    mask_nxt      = mask_r;
    obj_addr_nxt  = obj_addr_r;
    obj_data_nxt  = obj_data_r;
    vblank_nxt    = vblank_r;
    vaddr_nxt     = vaddr_r;
    taddr_nxt     = taddr_r;
    toggle_nxt    = toggle_r;
    buf_vld_nxt   = buf_vld_r;
    dot_nxt       = dot_r;
    line_nxt      = line_r;
    rd_data_nxt   = 8'h00;
    nmi_nxt       = 1'b0;
    frame_nxt     = 1'b0;
    ram_cmd       = '0;
    pal_we        = 1'b0;

    if (accept) begin
      case (in_func)
        FUNC_TICK: begin
          if (dot_sum >= DOTS_LIM) begin
            dot_nxt = '0;
            if (line_sum >= LINES_LIM) begin
              line_nxt  = '0;
              frame_nxt = 1'b1;
            end else begin
              line_nxt = line_sum[CNT_W-1:0];
            end
          end else begin
            dot_nxt = dot_sum[CNT_W-1:0];
          end
          if (line_nxt == VBLANK_SET_LINE && dot_nxt == CNT_W'(1)) begin
            vblank_nxt = 1'b1;
            nmi_nxt    = ctrl_r[CTRL_NMI_BIT];
          end
          if (line_nxt == VBLANK_CLR_LINE && dot_nxt == CNT_W'(1)) begin
            vblank_nxt = 1'b0;
          end
        end
        FUNC_READ: begin
          case (in_reg_select)
            REG_CTRL: begin
              rd_data_nxt = ctrl_r;
            end
            REG_STATUS: begin
              rd_data_nxt = {vblank_r, 7'd0};
              vblank_nxt  = 1'b0;
              toggle_nxt  = 1'b0;
            end
            REG_OBJ_DATA: begin
              rd_data_nxt = obj_data_r;
            end
            REG_DATA: begin
              rd_data_nxt = buf_val;
              ram_cmd.rd  = 1'b1;
              buf_vld_nxt = 1'b1;
              vaddr_nxt   = vaddr_r + vaddr_inc;
            end
            default: begin
            end
          endcase
        end
        FUNC_WRITE: begin
          case (in_reg_select)
            REG_CTRL: begin
              nmi_nxt  = !ctrl_r[CTRL_NMI_BIT] && in_write_data[CTRL_NMI_BIT] && vblank_r;
              ctrl_nxt = in_write_data;
            end
            REG_MASK: begin
              mask_nxt = in_write_data;
            end
            REG_OBJ_ADDR: begin
              obj_addr_nxt = in_write_data;
            end
            REG_OBJ_DATA: begin
              obj_data_nxt = in_write_data;
            end
            REG_ADDR: begin
              if (!toggle_r) begin
                taddr_nxt  = {in_write_data, taddr_r[7:0]};
                toggle_nxt = 1'b1;
              end else begin
                taddr_nxt  = {taddr_r[15:8], in_write_data};
                vaddr_nxt  = {taddr_r[15:8], in_write_data};
                toggle_nxt = 1'b0;
              end
            end
            REG_DATA: begin
              if (!vaddr_r[15] && vaddr_r >= PAL_BASE) begin
                pal_we = 1'b1;
              end else begin
                ram_cmd.wr = 1'b1;
              end
              vaddr_nxt = vaddr_r + vaddr_inc;
            end
            default: begin
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r      <= '0;
      mask_r      <= '0;
      obj_addr_r  <= '0;
      obj_data_r  <= '0;
      vblank_r    <= 1'b0;
      vaddr_r     <= '0;
      taddr_r     <= '0;
      toggle_r    <= 1'b0;
      buf_vld_r   <= 1'b0;
      dot_r       <= '0;
      line_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ctrl_r      <= ctrl_nxt;
      mask_r      <= mask_nxt;
      obj_addr_r  <= obj_addr_nxt;
      obj_data_r  <= obj_data_nxt;
      vblank_r    <= vblank_nxt;
      vaddr_r     <= vaddr_nxt;
      taddr_r     <= taddr_nxt;
      toggle_r    <= toggle_nxt;
      buf_vld_r   <= buf_vld_nxt;
      dot_r       <= dot_nxt;
      line_r      <= line_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload, loaded with each accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= rd_data_nxt;
      nmi_r     <= nmi_nxt;
      frame_r   <= frame_nxt;
    end
  end

  // palette bytes: written through the data port, never read back
  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[vaddr_r[PAL_AW-1:0]] <= in_write_data;
    end
  end

  vur_vram #(
    .VRAM_BYTES (VRAM_BYTES),
    .AW         (AW)
  ) u_vram (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (ram_cmd),
    .addr  (ram_addr),
    .wdata (in_write_data),
    .rdata (ram_rdata),
    .busy  (ram_busy)
  );

  assign out_valid      = out_valid_r;
  assign out_read_data  = rd_data_r;
  assign out_nmi_pulse  = nmi_r;
  assign out_frame_done = frame_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // no RAM access while the clear sweep owns the port
  a_no_access_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ram_busy |-> (!ram_cmd.wr && !ram_cmd.rd && !pal_we))
    else $error("video RAM accessed during clear sweep");

  // a pending frame_done item means the counters sit at the start of a frame
  a_frame_at_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && frame_r) |-> (line_r == '0 && dot_r == '0))
    else $error("frame_done without counters at frame start");

  // a pending NMI item implies vblank is still set
  a_nmi_in_vblank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && nmi_r) |-> vblank_r)
    else $error("NMI raised outside vblank");

  // vblank only holds between its set and clear points
  a_vblank_window: assert property (@(posedge clk) disable iff (!rst_n)
    vblank_r |-> ((line_r > VBLANK_SET_LINE || (line_r == VBLANK_SET_LINE && dot_r != '0)) &&
                  (line_r < VBLANK_CLR_LINE || (line_r == VBLANK_CLR_LINE && dot_r == '0))))
    else $error("vblank set outside its window");

endmodule
